// ===== sv/assert_macros.svh =====
// assertion helpers for the adder project
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");

// next-cycle implication checked outside reset
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");

`endif

// ===== sv/fpadd_pkg.sv =====
// ----------------------------------------------------------------------------
// fpadd_pkg
// constants and types shared by the single precision adder
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package fpadd_pkg;
    localparam logic [31:0] QNAN_BITS = 32'h7FC0_0000;
    localparam logic [7:0]  EXP_MAX   = 8'hFF;

    typedef logic [31:0] t_word;
endpackage

// ===== sv/fp32_adder_unit.sv =====
// ----------------------------------------------------------------------------
// fp32_adder_unit
// binary32 adder, truncating, four register stages
// ----------------------------------------------------------------------------
// channel   direction  signals
// operands  in         i_valid, o_ready, i_operand_a, i_operand_b
// sum       out        o_valid, i_ready, o_sum_bits
//
// one addition accepted per cycle while the pipeline advances; four register
// stages: unpack/align, add, leading zero count, and shift/pack. o_valid is the
// valid bit of the shift/pack stage, so the sum beat leaves from that register.
// synchronous active-low reset clears the stage valid bits only.
// the pipeline advances as a whole when the last stage is empty or is taken;
// on a stall every stage holds, so nothing is lost or repeated.
`timescale 1ns / 1ps
module fp32_adder_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  fpadd_pkg::t_word   i_operand_a,
    input  fpadd_pkg::t_word   i_operand_b,
    output logic               o_valid,
    input  logic               i_ready,
    output fpadd_pkg::t_word   o_sum_bits
);
    import fpadd_pkg::*;
`include "assert_macros.svh"

    logic adv;
    logic [3:0] r_v;
    assign adv = !r_v[3] || i_ready;
    assign o_ready = adv;
    assign o_valid = r_v[3];

    // stage 1: unpack, specials, align
    logic        r_s1_spec, r_s1_sub, r_s1_sa, r_s1_sb;
    logic [31:0] r_s1_sbits;
    logic [7:0]  r_s1_e;
    logic [23:0] r_s1_ma, r_s1_mb;
    logic        r_s1_agt;
    logic        sa, sb, nan_in, agt;
    logic [7:0]  ea, eb, ea1, eb1, d;
    logic [23:0] ma, mb;
    logic [31:0] sp_bits;
    logic        spec;
    always_comb begin
        sa = i_operand_a[31];
        sb = i_operand_b[31];
        ea = i_operand_a[30:23];
        eb = i_operand_b[30:23];
        nan_in = (ea == EXP_MAX && i_operand_a[22:0] != 23'd0) ||
                 (eb == EXP_MAX && i_operand_b[22:0] != 23'd0);
        spec = 1'b1;
        if (nan_in) sp_bits = QNAN_BITS;
        else if (ea == EXP_MAX) sp_bits = (eb == EXP_MAX && sa != sb) ? QNAN_BITS : i_operand_a;
        else if (eb == EXP_MAX) sp_bits = i_operand_b;
        else begin
            sp_bits = 32'd0;
            spec = 1'b0;
        end
        ma = {ea != 8'd0, i_operand_a[22:0]};
        mb = {eb != 8'd0, i_operand_b[22:0]};
        ea1 = (ea == 8'd0) ? 8'd1 : ea;
        eb1 = (eb == 8'd0) ? 8'd1 : eb;
        agt = ea1 > eb1;
        d = agt ? ea1 - eb1 : eb1 - ea1;
        if (agt) mb = (d >= 8'd24) ? 24'd0 : mb >> d[4:0];
        else     ma = (d >= 8'd24) ? 24'd0 : ma >> d[4:0];
    end
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_spec <= spec;
            r_s1_sbits <= sp_bits;
            r_s1_sa <= sa;
            r_s1_sb <= sb;
            r_s1_sub <= sa != sb;
            r_s1_e <= agt ? ea1 : eb1;
            r_s1_ma <= ma;
            r_s1_mb <= mb;
            r_s1_agt <= agt;
        end
    end

    // stage 2: magnitude add or subtract
    logic        r_s2_spec, r_s2_sub, r_s2_s;
    logic [31:0] r_s2_sbits;
    logic [7:0]  r_s2_e;
    logic [24:0] r_s2_m;
    logic        n_s;
    logic [24:0] n_m;
    always_comb begin
        if (!r_s1_sub) begin
            n_m = {1'b0, r_s1_ma} + {1'b0, r_s1_mb};
            n_s = r_s1_sa;
        end else if (r_s1_agt || r_s1_ma > r_s1_mb) begin
            n_m = {1'b0, r_s1_ma - r_s1_mb};
            n_s = r_s1_sa;
        end else begin
            n_m = {1'b0, r_s1_mb - r_s1_ma};
            n_s = r_s1_sb;
        end
    end
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s2_spec <= r_s1_spec;
            r_s2_sbits <= r_s1_sbits;
            r_s2_sub <= r_s1_sub;
            r_s2_s <= n_s;
            r_s2_e <= r_s1_e;
            r_s2_m <= n_m;
        end
    end

    // stage 3: carry handling and leading zero count
    logic        r_s3_spec, r_s3_done, r_s3_s;
    logic [31:0] r_s3_bits;
    logic [7:0]  r_s3_e;
    logic [23:0] r_s3_m;
    logic [4:0]  r_s3_lz;
    logic [4:0]  lz;
    logic        done;
    logic [31:0] dbits;
    always_comb begin
        lz = 5'd24;
        for (int i = 0; i < 24; i++) if (r_s2_m[i]) lz = 5'(23 - i);
        done = 1'b0;
        dbits = 32'd0;
        if (r_s2_m[24]) begin
            done = (r_s2_e + 8'd1) >= EXP_MAX;
            dbits = {r_s2_s, EXP_MAX, 23'd0};
        end else if (r_s2_m == 25'd0) begin
            done = 1'b1;
            dbits = r_s2_sub ? 32'd0 : {r_s2_s, 31'd0};
        end
    end
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s3_spec <= r_s2_spec || done;
            r_s3_bits <= r_s2_spec ? r_s2_sbits : dbits;
            r_s3_done <= r_s2_m[24];
            r_s3_s <= r_s2_s;
            r_s3_e <= r_s2_m[24] ? r_s2_e + 8'd1 : r_s2_e;
            r_s3_m <= r_s2_m[24] ? r_s2_m[24:1] : r_s2_m[23:0];
            r_s3_lz <= lz;
        end
    end

    // stage 4: left normalize and pack
    logic [31:0] r_s4_bits;
    logic [7:0]  sh;
    logic [23:0] nm;
    logic [7:0]  ne;
    always_comb begin
        sh = r_s3_done ? 8'd0 : {3'd0, r_s3_lz};
        if (sh > r_s3_e - 8'd1) sh = r_s3_e - 8'd1;
        nm = r_s3_m << sh[4:0];
        ne = r_s3_e - sh;
    end
    always_ff @(posedge i_clk) begin
        if (adv) begin
            if (r_s3_spec) r_s4_bits <= r_s3_bits;
            else r_s4_bits <= {r_s3_s, nm[23] ? ne : 8'd0, nm[22:0]};
        end
    end
    assign o_sum_bits = r_s4_bits;

    // stage valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v <= 4'd0;
        else if (adv) r_v <= {r_v[2:0], i_valid};
    end

    // quiet nan about to move into the output stage
    logic qnan_next;
    assign qnan_next = adv && r_v[2] && r_s3_spec && r_s3_bits == QNAN_BITS;

    `ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_sum_bits))
    `ASSERT_IMPL(a_ready_free, i_clk, i_rst_n, !o_valid, o_ready)
    `ASSERT_NEXT(a_nan_out, i_clk, i_rst_n, qnan_next, o_sum_bits == QNAN_BITS)
endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// self-checking bench for fp32_adder_unit: directed table of operand pairs,
// then random pairs biased toward special values, checked against a local
// truncating binary32 adder model, with bursty input and stalling output
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb;
    import fpadd_pkg::*;

    localparam int N_RANDOM    = 600;
    localparam int CYCLE_LIMIT = 200000;
    localparam int LONG_HOLD   = 60;
    localparam logic [31:0] INF_POS = 32'h7F80_0000;
    localparam logic [23:0] HIDDEN  = 24'h80_0000;

    logic  i_clk = 1'b0;
    logic  i_rst_n = 1'b0;
    logic  i_valid = 1'b0;
    logic  o_ready;
    t_word i_operand_a = '0;
    t_word i_operand_b = '0;
    logic  o_valid;
    logic  i_ready = 1'b0;
    t_word o_sum_bits;

    fp32_adder_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_operand_a(i_operand_a), .i_operand_b(i_operand_b),
        .o_valid(o_valid), .i_ready(i_ready), .o_sum_bits(o_sum_bits)
    );

    // clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    t_word sum_queue[$];
    int    n_errors = 0;
    int    cycle_count = 0;
    bit    stim_done = 1'b0;
    bit    hold_off = 1'b0;

    // truncating binary32 sum of two raw patterns
    function automatic t_word fp_sum(t_word a, t_word b);
        logic       sa, sb, s;
        logic [8:0] ea, eb, e, d;
        logic [24:0] ma, mb, m;
        sa = a[31]; sb = b[31];
        ea = {1'b0, a[30:23]}; eb = {1'b0, b[30:23]};
        if ((a[30:23] == EXP_MAX && a[22:0] != 0) || (b[30:23] == EXP_MAX && b[22:0] != 0))
            return QNAN_BITS;
        if (a[30:23] == EXP_MAX) begin
            if (b[30:23] == EXP_MAX && sa != sb) return QNAN_BITS;
            return a;
        end
        if (b[30:23] == EXP_MAX) return b;
        ma = {2'b0, a[22:0]}; mb = {2'b0, b[22:0]};
        if (ea != 0) ma[23] = 1'b1; else ea = 9'd1;
        if (eb != 0) mb[23] = 1'b1; else eb = 9'd1;
        if (ea > eb) begin
            d = ea - eb; mb = (d >= 32) ? '0 : (mb >> d); e = ea;
        end else begin
            d = eb - ea; ma = (d >= 32) ? '0 : (ma >> d); e = eb;
        end
        if (sa == sb) begin
            m = ma + mb; s = sa;
            if (m[24]) begin
                m = m >> 1; e = e + 9'd1;
                if (e >= EXP_MAX) return {s, INF_POS[30:0]};
            end
            if (m == 0) return {s, 31'b0};
        end else begin
            if (ea > eb || (ea == eb && ma > mb)) begin
                m = ma - mb; s = sa;
            end else begin
                m = mb - ma; s = sb;
            end
            if (m == 0) return '0;
            while (m[23] == 1'b0 && e > 1) begin
                m = m << 1; e = e - 9'd1;
            end
        end
        if (m[23] == 1'b0) return {s, 8'h00, m[22:0]};
        return {s, e[7:0], m[22:0]};
    endfunction

    // random operand with weight on special encodings
    function automatic t_word pick_operand();
        t_word w;
        w = $urandom;
        case ($urandom_range(0, 9))
            0: w[30:23] = EXP_MAX;
            1: begin w[30:23] = EXP_MAX; w[22:0] = '0; end
            2: w[30:23] = 8'h00;
            3: w[30:0] = '0;
            4: w[30:23] = 8'hFE;
            default: ;
        endcase
        return w;
    endfunction

    // directed rows: a, b, typed expectation, whether it is typed
    typedef struct packed {
        t_word a;
        t_word b;
        t_word sum;
        bit    typed;
    } t_row;

    t_row dir_rows[] = '{
        '{32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1},
        '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1},
        '{32'h8000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1},
        '{32'h7FC0_0001, 32'h3F80_0000, QNAN_BITS,     1'b1},
        '{32'h3F80_0000, 32'hFFFF_FFFF, QNAN_BITS,     1'b1},
        '{32'h7F80_0000, 32'hFF80_0000, QNAN_BITS,     1'b1},
        '{32'h7F80_0000, 32'h7F80_0000, 32'h7F80_0000, 1'b1},
        '{32'hFF80_0000, 32'h3F80_0000, 32'hFF80_0000, 1'b1},
        '{32'h3F80_0000, 32'h7F80_0000, 32'h7F80_0000, 1'b1},
        '{32'h3F80_0000, 32'hBF80_0000, 32'h0000_0000, 1'b1},
        '{32'h7F7F_FFFF, 32'h7F7F_FFFF, 32'h7F80_0000, 1'b1},
        '{32'hFF7F_FFFF, 32'hFF7F_FFFF, 32'hFF80_0000, 1'b1},
        '{32'h3F80_0000, 32'h3F80_0000, 32'h4000_0000, 1'b1},
        '{32'h0000_0001, 32'h0000_0001, 32'h0000_0002, 1'b1},
        '{32'h007F_FFFF, 32'h0000_0001, 32'h0080_0000, 1'b1},
        '{32'h0080_0000, 32'h8000_0001, 32'h0, 1'b0},
        '{32'h3F80_0001, 32'hBF80_0000, 32'h0, 1'b0},
        '{32'h7F00_0000, 32'h0000_0001, 32'h0, 1'b0},
        '{32'h4B80_0000, 32'hBF80_0000, 32'h0, 1'b0},
        '{32'h3F80_0000, 32'hBFC0_0000, 32'h0, 1'b0},
        '{32'hBFC0_0000, 32'h3F80_0000, 32'h0, 1'b0},
        '{32'h3FFF_FFFF, 32'h3FFF_FFFF, 32'h0, 1'b0},
        '{32'h7FFF_FFFF, 32'h0000_0000, QNAN_BITS,     1'b1}
    };

    // offer one beat and wait for acceptance
    task automatic send_pair(t_word a, t_word b, t_word exp_sum);
        i_valid     <= 1'b1;
        i_operand_a <= a;
        i_operand_b <= b;
        sum_queue.push_back(exp_sum);
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic idle_cycles(int n);
        i_valid <= 1'b0;
        repeat (n) @(negedge i_clk);
    endtask

    // sender
    initial begin
        t_word a, b;
        int burst;
        int sent;
        bit drained;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        foreach (dir_rows[i]) begin
            send_pair(dir_rows[i].a, dir_rows[i].b,
                      dir_rows[i].typed ? dir_rows[i].sum
                                        : fp_sum(dir_rows[i].a, dir_rows[i].b));
            if ($urandom_range(0, 3) == 0) idle_cycles($urandom_range(1, 3));
        end
        // drain fully before the random part
        i_valid <= 1'b0;
        @(negedge i_clk);
        while (sum_queue.size() != 0) @(negedge i_clk);
        sent = 0;
        drained = 1'b0;
        while (sent < N_RANDOM) begin
            burst = $urandom_range(1, 24);
            if (sent >= 200) hold_off = 1'b1;
            for (int k = 0; k < burst && sent < N_RANDOM; k++) begin
                a = pick_operand();
                b = pick_operand();
                if ($urandom_range(0, 7) == 0) b = {~a[31], a[30:0]};
                send_pair(a, b, fp_sum(a, b));
                sent++;
            end
            if (sent >= 400 && !drained) begin
                drained = 1'b1;
                i_valid <= 1'b0;
                @(negedge i_clk);
                while (sum_queue.size() != 0) @(negedge i_clk);
            end
            if ($urandom_range(0, 2) != 0) idle_cycles($urandom_range(1, 6));
        end
        i_valid <= 1'b0;
        stim_done = 1'b1;
    end

    // receiver stall pattern, with one long hold-off
    initial begin
        int pattern;
        int hold;
        pattern = $urandom_range(0, 3);
        hold = 0;
        forever begin
            @(negedge i_clk);
            if (hold_off && hold < LONG_HOLD) begin
                i_ready <= 1'b0;
                hold++;
            end else begin
                if ($urandom_range(0, 49) == 0) pattern = $urandom_range(0, 3);
                case (pattern)
                    0: i_ready <= 1'b1;
                    1: i_ready <= ($urandom_range(0, 1) == 1);
                    2: i_ready <= ($urandom_range(0, 4) == 0);
                    default: i_ready <= (cycle_count % 3 != 0);
                endcase
            end
        end
    end

    // result check
    always @(posedge i_clk) begin
        t_word want;
        if (i_rst_n && o_valid && i_ready) begin
            if (sum_queue.size() == 0) begin
                $display("%0t: unexpected sum beat, actual %08h", $time, o_sum_bits);
                n_errors++;
            end else begin
                want = sum_queue.pop_front();
                if (o_sum_bits !== want) begin
                    $display("%0t: sum_bits mismatch, expected %08h actual %08h",
                             $time, want, o_sum_bits);
                    n_errors++;
                end
            end
        end
    end

    // end of run and timeout
    initial begin
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT) begin
                $display("%0t: timeout", $time);
                $display("simulation failed");
                $finish;
            end
            if (stim_done && sum_queue.size() == 0) begin
                repeat (20) @(posedge i_clk);
                if (n_errors == 0 && sum_queue.size() == 0) begin
                    $display("simulation ok");
                end else begin
                    $display("simulation failed");
                end
                $finish;
            end
        end
    end
endmodule
